// ===== hw/rtl/lzd_pkg.sv =====
// Shared types and constants of the LZSS stream decompressor.
package lzd_pkg;

  // Parser phase codes.
  localparam logic [2:0] PH_FIRST = 3'd0;
  localparam logic [2:0] PH_RAW   = 3'd1;
  localparam logic [2:0] PH_TAG   = 3'd2;
  localparam logic [2:0] PH_OBJ   = 3'd3;
  localparam logic [2:0] PH_REFHI = 3'd4;
  localparam logic [2:0] PH_COPY  = 3'd5;

  // First byte that selects the pass-through mode.
  localparam logic [7:0] RAW_MARK = 8'h01;

  // Tag value once all eight flag bits are shifted out and only the marker bit is left.
  localparam logic [8:0] TAG_EMPTY = 9'h001;

  // Smallest copy length, and the width of a reference in bits.
  localparam logic [5:0] LEN_BIAS = 6'd3;
  localparam logic [4:0] REF_BITS = 5'd16;

  // Smallest window and the window after reset.
  localparam logic [4:0] WIN_MIN   = 5'd11;
  localparam logic [3:0] WIN_RESET = 4'd12;

  // Start of a copy run.
  typedef struct packed {
    logic       start;
    logic       last;
    logic [5:0] len;
  } copy_cmd_t;

  // One byte produced by the copy engine.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       run_last;
    logic       stream_end;
  } beat_t;

endpackage

// ===== hw/rtl/lzd_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module lzd_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/lzd_copy.sv =====
// Copy engine: reads the history one byte at a time and hands each byte on.
module lzd_copy #(
  parameter int HISTORY_BITS = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lzd_pkg::copy_cmd_t        cmd_i,
  input  logic [HISTORY_BITS-1:0]   src_i,
  input  logic [HISTORY_BITS-1:0]   ring_i,
  input  logic                      out_free_i,
  input  logic [7:0]                rd_data_i,
  output logic                      rd_en_o,
  output logic [HISTORY_BITS-1:0]   rd_addr_o,
  output lzd_pkg::beat_t            beat_o
);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_RD   = 2'd1;
  localparam logic [1:0] C_WR   = 2'd2;

  logic [1:0]              st_q, st_d;
  logic [HISTORY_BITS-1:0] src_q, src_d;
  logic [5:0]              cnt_q, cnt_d;
  logic                    last_q, last_d;
  logic                    final_beat;

  assign final_beat = (cnt_q == 6'd1);

  // Sequencer: one read step, then one write and output step per byte.
  always_comb begin
    st_d    = st_q;
    src_d   = src_q;
    cnt_d   = cnt_q;
    last_d  = last_q;
    rd_en_o = 1'b0;
    beat_o  = '0;
    case (st_q)
      C_IDLE: begin
        if (cmd_i.start) begin
          src_d  = src_i;
          cnt_d  = cmd_i.len;
          last_d = cmd_i.last;
          st_d   = C_RD;
        end
      end
      C_RD: begin
        rd_en_o = 1'b1;
        src_d   = (src_q + 1'b1) & ring_i;
        st_d    = C_WR;
      end
      C_WR: begin
        if (out_free_i) begin
          beat_o.valid      = 1'b1;
          beat_o.data       = rd_data_i;
          beat_o.run_last   = final_beat;
          beat_o.stream_end = final_beat && last_q;
          cnt_d             = cnt_q - 1'b1;
          st_d              = final_beat ? C_IDLE : C_RD;
        end
      end
      default: begin
        st_d = C_IDLE;
      end
    endcase
  end

  assign rd_addr_o = src_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= C_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // Run payload.
  always_ff @(posedge clk_i) begin
    src_q  <= src_d;
    cnt_q  <= cnt_d;
    last_q <= last_d;
  end

endmodule

// ===== hw/rtl/lzss_stream_decompressor.sv =====
// Top level of the LZSS stream decompressor: parser, history and output register.
//
//  Channel   Direction  tdata           tlast         tuser
//  s_axis    in         comp_byte       stream_last   -
//  m_axis    out        data_byte       stream_end    [0] run_last, [1] format_error
//  cfg       in         window_bits     -             -
//
// Tag, raw, literal and reference low bytes are each decoded as they are taken.
// A reference takes its high byte and then, for each copied byte, a history
// read followed by a history write and output.
// The history RAM has no clearing pass; it is usable right after reset.
// Input is taken only while the parser is not copying and the output register
// is empty or draining; a stalled output freezes the copy engine in place.
module lzss_stream_decompressor #(
  parameter int HISTORY_BITS = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration: window_bits.
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  // Compressed input stream.
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] comp_byte
  input  logic       s_axis_tlast,
  // Decompressed output stream.
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] data_byte
  output logic       m_axis_tlast,
  output logic [1:0] m_axis_tuser    // [0] run_last, [1] format_error
);

  localparam int          HistDepth = 1 << HISTORY_BITS;
  localparam logic [4:0]  HistBitsW = 5'(HISTORY_BITS);

  logic [3:0]              win_q;
  logic [4:0]              win_eff;
  logic [4:0]              len_bits;
  logic [HISTORY_BITS-1:0] ring;

  logic [2:0]              ph_q, ph_d;
  logic [8:0]              tag_q, tag_d;
  logic [8:0]              tag_shift;
  logic [7:0]              offl_q, offl_d;
  logic [HISTORY_BITS-1:0] wp_q, wp_d;

  logic                    out_free;
  logic                    s_fire;
  logic                    par_emit;
  logic [7:0]              par_data;
  logic                    par_end;
  logic                    par_err;
  logic                    lit_we;

  logic [7:0]              ref_hi;
  logic [15:0]             ref_off;
  logic [7:0]              len_field;
  logic [HISTORY_BITS-1:0] ref_src;
  lzd_pkg::copy_cmd_t      cmd;
  lzd_pkg::beat_t          beat;

  logic                    rd_en;
  logic [HISTORY_BITS-1:0] rd_addr;
  logic [7:0]              rd_data;
  logic                    mem_we;
  logic [7:0]              mem_wdata;

  logic                    m_valid_q;
  logic [7:0]              m_data_q;
  logic                    m_end_q;
  logic                    m_run_q;
  logic                    m_err_q;

  // Window register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= lzd_pkg::WIN_RESET;
    end else if (cfg_we_i) begin
      win_q <= cfg_wdata_i;
    end
  end

  // Effective window, ring mask and length field width.
  always_comb begin
    win_eff = {1'b0, win_q};
    if (win_eff < lzd_pkg::WIN_MIN) begin
      win_eff = lzd_pkg::WIN_MIN;
    end
    if (win_eff > HistBitsW) begin
      win_eff = HistBitsW;
    end
  end

  assign ring     = {HISTORY_BITS{1'b1}} >> (HistBitsW - win_eff);
  assign len_bits = lzd_pkg::REF_BITS - win_eff;

  // Reference decode from the high byte and the stored low byte.
  assign ref_hi    = s_axis_tdata;
  assign ref_off   = {8'(ref_hi >> len_bits), offl_q};
  assign len_field = ref_hi & ~(8'hFF << len_bits);
  assign ref_src   = (wp_q - ref_off[HISTORY_BITS-1:0]) & ring;

  // Handshake.
  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (ph_q != lzd_pkg::PH_COPY) && out_free;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign tag_shift     = tag_q >> 1;

  // Parser.
  always_comb begin
    ph_d     = ph_q;
    tag_d    = tag_q;
    offl_d   = offl_q;
    wp_d     = wp_q;
    par_emit = 1'b0;
    par_data = s_axis_tdata;
    par_end  = s_axis_tlast;
    par_err  = 1'b0;
    lit_we   = 1'b0;
    cmd      = '0;
    if (s_fire) begin
      case (ph_q)
        lzd_pkg::PH_FIRST, lzd_pkg::PH_TAG: begin
          if (ph_q == lzd_pkg::PH_FIRST && s_axis_tdata == lzd_pkg::RAW_MARK) begin
            ph_d = s_axis_tlast ? lzd_pkg::PH_FIRST : lzd_pkg::PH_RAW;
          end else if (s_axis_tlast) begin
            par_emit = 1'b1;
            par_err  = 1'b1;
            par_data = '0;
          end else begin
            tag_d = {1'b1, s_axis_tdata};
            ph_d  = lzd_pkg::PH_OBJ;
          end
        end
        lzd_pkg::PH_RAW: begin
          par_emit = 1'b1;
        end
        lzd_pkg::PH_OBJ: begin
          tag_d = tag_shift;
          if (!tag_q[0]) begin
            par_emit = 1'b1;
            lit_we   = 1'b1;
            wp_d     = (wp_q + 1'b1) & ring;
            ph_d     = (tag_shift == lzd_pkg::TAG_EMPTY) ? lzd_pkg::PH_TAG
                                                          : lzd_pkg::PH_OBJ;
          end else if (s_axis_tlast) begin
            par_emit = 1'b1;
            par_err  = 1'b1;
            par_data = '0;
          end else begin
            offl_d = s_axis_tdata;
            ph_d   = lzd_pkg::PH_REFHI;
          end
        end
        lzd_pkg::PH_REFHI: begin
          cmd.start = 1'b1;
          cmd.last  = s_axis_tlast;
          cmd.len   = 6'(len_field[4:0]) + lzd_pkg::LEN_BIAS;
          ph_d      = lzd_pkg::PH_COPY;
        end
        default: begin
          ph_d = lzd_pkg::PH_FIRST;
        end
      endcase
      // Any byte marked last ends the stream, except the start of a copy run.
      if (s_axis_tlast && ph_q != lzd_pkg::PH_REFHI) begin
        ph_d   = lzd_pkg::PH_FIRST;
        tag_d  = '0;
        offl_d = '0;
        wp_d   = '0;
      end
    end else if (ph_q == lzd_pkg::PH_COPY && beat.valid) begin
      // Copy run: advance the write pointer with each byte, finish on the last.
      wp_d = (wp_q + 1'b1) & ring;
      if (beat.run_last) begin
        if (beat.stream_end) begin
          ph_d   = lzd_pkg::PH_FIRST;
          tag_d  = '0;
          offl_d = '0;
          wp_d   = '0;
        end else begin
          ph_d = (tag_q == lzd_pkg::TAG_EMPTY) ? lzd_pkg::PH_TAG : lzd_pkg::PH_OBJ;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= lzd_pkg::PH_FIRST;
      tag_q  <= '0;
      offl_q <= '0;
      wp_q   <= '0;
    end else begin
      ph_q   <= ph_d;
      tag_q  <= tag_d;
      offl_q <= offl_d;
      wp_q   <= wp_d;
    end
  end

  // Copy engine.
  lzd_copy #(
    .HISTORY_BITS(HISTORY_BITS)
  ) u_copy (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .src_i      (ref_src),
    .ring_i     (ring),
    .out_free_i (out_free),
    .rd_data_i  (rd_data),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .beat_o     (beat)
  );

  // History write: a literal from the parser or a byte from the copy engine.
  assign mem_we    = lit_we || beat.valid;
  assign mem_wdata = lit_we ? s_axis_tdata : beat.data;

  lzd_ram #(
    .Width(8),
    .Depth(HistDepth)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wp_q & ring),
    .wdata_i (mem_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (par_emit || beat.valid) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (par_emit) begin
      m_data_q <= par_data;
      m_run_q  <= 1'b1;
      m_end_q  <= par_end;
      m_err_q  <= par_err;
    end else if (beat.valid) begin
      m_data_q <= beat.data;
      m_run_q  <= beat.run_last;
      m_end_q  <= beat.stream_end;
      m_err_q  <= 1'b0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_end_q;
  assign m_axis_tuser  = {m_err_q, m_run_q};

endmodule

// ===== hw/rtl/lzd_checker.sv =====
// Port-level checks of the LZSS stream decompressor, bound to its top level.
module lzd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [1:0] m_axis_tuser
);

  // An error result carries a zero byte and closes both the run and the stream.
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |->
      (m_axis_tdata == 8'h00 && m_axis_tuser[0] && m_axis_tlast))
    else $error("format error result has wrong shape");

  // The end of a stream is always the end of a run.
  a_end_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser[0])
    else $error("stream end without run end");

  // No input is taken while a result is held back.
  a_no_take_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input ready while output stalled");

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled output changed");

endmodule

bind lzss_stream_decompressor lzd_checker u_lzd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== sim/tb_top.sv =====
// Testbench of the LZSS stream decompressor: directed table, random streams and a decode model.
module tb_top;

  localparam int HIST_BITS     = 12;
  localparam int HIST_SIZE     = 1 << HIST_BITS;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_ITEMS  = 180;
  localparam int N_PHASES      = 6;
  localparam int RX_HOLD       = 400;

  // How a generated compressed stream ends.
  typedef enum int {TAIL_CLEAN, TAIL_ON_TAG, TAIL_ON_LOW} tail_kind_e;

  // One decompressed byte as seen on the output stream.
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       stream_end;
    logic       format_error;
  } out_byte_t;

  // One row of the directed table; res is used only where typed is set.
  typedef struct packed {
    logic [7:0] comp;
    logic       last;
    logic       typed;
    out_byte_t  res;
  } dir_row_t;

  localparam out_byte_t FMT_ERR = '{8'h00, 1'b1, 1'b1, 1'b1};
  localparam out_byte_t NO_RES  = '0;

  // Window register values used by the random phases, out-of-range codes included.
  localparam logic [3:0] WIN_PLAN [N_PHASES] = '{4'd11, 4'd15, 4'd0, 4'd12, 4'd13, 4'd11};
  localparam logic [3:0] WIN_MID_STREAM = 4'd5;

  // Directed streams: errors, empty and short raw streams, long and overlapping
  // copies, a zero offset into stale history and a maximal offset that wraps.
  localparam dir_row_t DIR_ROWS [22] = '{
    '{8'hFF, 1'b1, 1'b1, FMT_ERR},                   // first byte marked last
    '{8'h01, 1'b1, 1'b0, NO_RES},                    // empty raw stream
    '{8'h01, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
    '{8'h01, 1'b0, 1'b1, '{8'h01, 1'b1, 1'b0, 1'b0}},
    '{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0}},
    '{8'h06, 1'b0, 1'b0, NO_RES},                    // literal, two references, literals
    '{8'hA5, 1'b0, 1'b0, NO_RES},
    '{8'h01, 1'b0, 1'b0, NO_RES},
    '{8'h0F, 1'b0, 1'b0, NO_RES},                    // offset 1, longest run: repeats
    '{8'h13, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b1, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, NO_RES},                    // all references
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},                    // zero offset reads stale bytes
    '{8'h00, 1'b1, 1'b1, FMT_ERR},                   // low byte marked last
    '{8'h02, 1'b0, 1'b0, NO_RES},
    '{8'h3C, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b1, 1'b0, NO_RES}                     // largest offset, stream ends on copy
  };

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic [3:0] cfg_wdata_i   = lzd_pkg::WIN_RESET;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] comp_byte
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] data_byte
  logic       m_axis_tlast;
  logic [1:0] m_axis_tuser;           // [0] run_last, [1] format_error

  // Decoder model state.
  logic [2:0]           dec_phase  = lzd_pkg::PH_FIRST;
  logic [8:0]           dec_tag    = '0;
  logic [7:0]           dec_off_lo = '0;
  logic [HIST_BITS-1:0] dec_wp     = '0;
  logic [7:0]           dec_hist [HIST_SIZE];
  bit                   dec_written [HIST_SIZE];
  logic [3:0]           win_reg    = lzd_pkg::WIN_RESET;

  out_byte_t step_res[$];
  out_byte_t expected_bytes[$];
  out_byte_t want_byte;

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_hold = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int in_count = 0;
  int out_count = 0;
  int n_streams = 0;
  int n_refs = 0;
  int n_fmt_errs = 0;
  int n_windows = 0;

  always #10 clk_i = ~clk_i;

  lzss_stream_decompressor #(
    .HISTORY_BITS(HIST_BITS)
  ) uut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .m_axis_tuser
  );

  // Window in use: the register clamped to the legal range.
  function automatic int eff_window(input logic [3:0] v);
    int w = v;
    if (w < lzd_pkg::WIN_MIN) w = lzd_pkg::WIN_MIN;
    if (w > HIST_BITS) w = HIST_BITS;
    return w;
  endfunction

  function automatic void restart_stream();
    dec_phase  = lzd_pkg::PH_FIRST;
    dec_tag    = '0;
    dec_off_lo = '0;
    dec_wp     = '0;
  endfunction

  // Append one byte to the history ring and advance the write pointer.
  function automatic void put_hist(input logic [7:0] v, input int ring);
    int idx = int'(dec_wp) & ring;
    dec_hist[idx]    = v;
    dec_written[idx] = 1'b1;
    dec_wp           = HIST_BITS'((idx + 1) & ring);
  endfunction

  // Decode one compressed byte and leave the bytes it produces in step_res.
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    int w, ring, lenbits, pos, len, src;
    logic [7:0] v;
    w       = eff_window(win_reg);
    ring    = (1 << w) - 1;
    lenbits = int'(lzd_pkg::REF_BITS) - w;
    step_res.delete();
    case (dec_phase)
      lzd_pkg::PH_FIRST, lzd_pkg::PH_TAG: begin
        if (dec_phase == lzd_pkg::PH_FIRST && b == lzd_pkg::RAW_MARK) begin
          if (last) restart_stream();
          else dec_phase = lzd_pkg::PH_RAW;
        end else if (last) begin
          step_res.push_back(FMT_ERR);
          n_fmt_errs++;
          restart_stream();
        end else begin
          dec_tag   = {1'b1, b};
          dec_phase = lzd_pkg::PH_OBJ;
        end
      end
      lzd_pkg::PH_RAW: begin
        step_res.push_back('{b, 1'b1, last, 1'b0});
        if (last) restart_stream();
      end
      lzd_pkg::PH_OBJ: begin
        if (!dec_tag[0]) begin
          dec_tag = dec_tag >> 1;
          put_hist(b, ring);
          step_res.push_back('{b, 1'b1, last, 1'b0});
          if (last) restart_stream();
          else dec_phase = (dec_tag == lzd_pkg::TAG_EMPTY) ? lzd_pkg::PH_TAG
                                                           : lzd_pkg::PH_OBJ;
        end else begin
          dec_tag = dec_tag >> 1;
          if (last) begin
            step_res.push_back(FMT_ERR);
            n_fmt_errs++;
            restart_stream();
          end else begin
            dec_off_lo = b;
            dec_phase  = lzd_pkg::PH_REFHI;
          end
        end
      end
      lzd_pkg::PH_REFHI: begin
        // Copy byte by byte so that overlapping runs repeat.
        pos = int'(dec_off_lo) | ((int'(b) >> lenbits) << 8);
        len = (int'(b) & ((1 << lenbits) - 1)) + int'(lzd_pkg::LEN_BIAS);
        src = (int'(dec_wp) - pos) & ring;
        for (int i = 0; i < len; i++) begin
          v = dec_hist[src];
          put_hist(v, ring);
          src = (src + 1) & ring;
          step_res.push_back('{v, i == len - 1, last && (i == len - 1), 1'b0});
        end
        n_refs++;
        if (last) restart_stream();
        else dec_phase = (dec_tag == lzd_pkg::TAG_EMPTY) ? lzd_pkg::PH_TAG
                                                         : lzd_pkg::PH_OBJ;
      end
      default: restart_stream();
    endcase
  endfunction

  // A copy is safe when every byte it reads was written before, either by an
  // earlier transfer or earlier in the group that is being built.
  function automatic bit copy_is_safe(input int base, input int done, input int pos,
                                      input int len, input int ring);
    int rd;
    for (int i = 0; i < len; i++) begin
      rd = (base + done - pos + i) & ring;
      if (!dec_written[rd] && (((rd - base) & ring) >= done + i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Offer one compressed byte; the model decodes it once the transfer happens.
  task automatic send_item(input logic [7:0] b, input logic last, input logic typed,
                           input out_byte_t res);
    int gap;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decode_byte(b, last);
    if (typed) expected_bytes.push_back(res);
    else foreach (step_res[j]) expected_bytes.push_back(step_res[j]);
    in_count++;
    if (last) n_streams++;
  endtask

  // Stop offering input until every decoded byte has come out, then let the block settle.
  task automatic pause_until_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [3:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    win_reg = v;
    n_windows++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return lzd_pkg::RAW_MARK;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_raw_stream(input int n);
    send_item(lzd_pkg::RAW_MARK, n == 0, 1'b0, NO_RES);
    for (int i = 0; i < n; i++) send_item(pick_byte(), i == n - 1, 1'b0, NO_RES);
  endtask

  // Build one tag group against the current history and send it. References
  // that would read unwritten history are turned into literals.
  task automatic send_group(input bit first_grp, input int nobj, input bit last_grp,
                            input tail_kind_e tail);
    int w, ring, lenbits, base, done, pos, len, tries;
    logic [7:0] tag;
    logic [7:0] obj_q[$];
    bit low_tail, safe;
    w        = eff_window(win_reg);
    ring     = (1 << w) - 1;
    lenbits  = int'(lzd_pkg::REF_BITS) - w;
    base     = int'(dec_wp) & ring;
    done     = 0;
    case ($urandom_range(0, 5))
      0: tag = 8'h00;
      1: tag = 8'hFF;
      default: tag = 8'($urandom_range(0, 255));
    endcase
    if (first_grp && tag == lzd_pkg::RAW_MARK) tag = 8'h81;
    low_tail = last_grp && (tail == TAIL_ON_LOW);
    if (low_tail) tag[nobj-1] = 1'b1;
    for (int k = 0; k < nobj; k++) begin
      if (tag[k] && low_tail && k == nobj - 1) begin
        obj_q.push_back(8'($urandom_range(0, 255)));
      end else if (tag[k]) begin
        safe = 1'b0;
        for (tries = 0; tries < 8 && !safe; tries++) begin
          case ($urandom_range(0, 9))
            0: pos = 0;
            1, 2: pos = $urandom_range(0, ring);
            default: pos = $urandom_range(1, 24);
          endcase
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(3, (1 << lenbits) + 2)
                                             : $urandom_range(3, 6);
          safe = copy_is_safe(base, done, pos, len, ring);
        end
        if (safe) begin
          obj_q.push_back(pos[7:0]);
          obj_q.push_back(8'(((pos >> 8) << lenbits) | (len - int'(lzd_pkg::LEN_BIAS))));
          done += len;
        end else begin
          tag[k] = 1'b0;
          obj_q.push_back(pick_byte());
          done++;
        end
      end else begin
        obj_q.push_back(pick_byte());
        done++;
      end
    end
    send_item(tag, 1'b0, 1'b0, NO_RES);
    foreach (obj_q[j]) begin
      send_item(obj_q[j], last_grp && (tail != TAIL_ON_TAG) && (j == obj_q.size() - 1),
                1'b0, NO_RES);
    end
  endtask

  // A compressed stream of one or more groups; a window change may fall after the first one.
  task automatic send_lz_stream(input int groups, input tail_kind_e tail, input bit mid_change);
    int nobj;
    for (int g = 0; g < groups; g++) begin
      nobj = (g == groups - 1 && tail != TAIL_ON_TAG) ? $urandom_range(1, 8) : 8;
      send_group(g == 0, nobj, g == groups - 1, tail);
      if (g == 0 && mid_change && groups > 1) begin
        pause_until_idle();
        write_window(WIN_MID_STREAM);
      end
    end
    if (tail == TAIL_ON_TAG) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, NO_RES);
  endtask

  // Output side: a random hold-off before each transfer while rx_idle is set, or one long stall on request.
  initial begin : rx_side
    int w;
    forever begin
      if (rx_hold > 0) begin
        w = rx_hold;
        rx_hold = 0;
      end else begin
        w = rx_idle ? $urandom_range(0, 8) : 0;
      end
      repeat (w) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each output transfer with the oldest expected byte.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      out_count++;
      if (expected_bytes.size() == 0) begin
        $error("unexpected output transfer: data_byte %0h", m_axis_tdata);
        mismatches++;
      end else begin
        want_byte = expected_bytes.pop_front();
        check_field("data_byte", want_byte.data, m_axis_tdata);
        check_field("run_last", want_byte.run_last, m_axis_tuser[0]);
        check_field("stream_end", want_byte.stream_end, m_axis_tlast);
        check_field("format_error", want_byte.format_error, m_axis_tuser[1]);
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Stimulus: reset, directed table, then random phases under several windows.
  initial begin : stimulus
    int phase_start;
    int pick;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIR_ROWS[r]) begin
      send_item(DIR_ROWS[r].comp, DIR_ROWS[r].last, DIR_ROWS[r].typed, DIR_ROWS[r].res);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      pause_until_idle();
      write_window(WIN_PLAN[p]);
      tx_idle = (p % 3) != 1;
      rx_idle = (p % 3) != 2;
      if (p == 2) rx_hold = RX_HOLD;
      phase_start = in_count;
      if (p == 4) send_lz_stream(2, TAIL_CLEAN, 1'b1);
      while (in_count - phase_start < RANDOM_ITEMS / N_PHASES) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) send_raw_stream($urandom_range(0, 6));
        else if (pick == 1) send_lz_stream($urandom_range(1, 2), TAIL_ON_TAG, 1'b0);
        else if (pick == 2) send_lz_stream($urandom_range(1, 2), TAIL_ON_LOW, 1'b0);
        else send_lz_stream($urandom_range(1, 3), TAIL_CLEAN, 1'b0);
      end
    end
    pause_until_idle();

    $display("Run: %0d compressed bytes in %0d streams, %0d references, %0d format errors.",
             in_count, n_streams, n_refs, n_fmt_errs);
    $display("Run: %0d output bytes checked across %0d window writes and a long output stall.",
             out_count, n_windows);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
